>>> hdl/msss_pkg.sv
// ---------------------------------------------------------------------------
// msss_pkg: shared types and constants for the seven-segment scan driver
// Digit encoding, BCD geometry and the converter status bundle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msss_pkg;

    localparam int VALUE_W  = 27;               // width of the input value
    localparam int DIGITS   = 8;                // BCD digits held by the converter
    localparam int BCD_W    = 4 * DIGITS;
    localparam int SEG_W    = 7;
    localparam int IDX_W    = 3;                // digit index 0..7
    localparam int STEP_W   = 5;                // conversion step count 0..26

    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [3:0]       digit_t;
    typedef logic [SEG_W-1:0] seg_t;

    typedef struct packed {
        logic busy;     // conversion running
        logic done;     // last shift happens this cycle
    } dab_stat_t;

    // 10^n, evaluated at elaboration only
    function automatic int unsigned pow10(input int n);
        int unsigned acc;
        acc = 1;
        for (int i = 0; i < n; i++) begin
            acc = acc * 10;
        end
        return acc;
    endfunction

    // active-high gfedcba pattern
    function automatic seg_t seg_encode(input digit_t d);
        seg_t s;
        unique case (d)
            4'd0:    s = 7'h3f;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5b;
            4'd3:    s = 7'h4f;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6d;
            4'd6:    s = 7'h7d;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7f;
            4'd9:    s = 7'h6f;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> hdl/msss_dabble.sv
// ---------------------------------------------------------------------------
// msss_dabble: iterative binary to BCD converter
// Shift-and-add-3, one input bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msss_dabble (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [msss_pkg::VALUE_W-1:0]  value,
    output msss_pkg::bcd_t                     bcd,
    output msss_pkg::dab_stat_t                stat
);

    localparam logic [msss_pkg::STEP_W-1:0] LAST_STEP =
        msss_pkg::STEP_W'(msss_pkg::VALUE_W - 1);

    logic [msss_pkg::VALUE_W-1:0] bin_reg, bin_next;
    msss_pkg::bcd_t               bcd_reg, bcd_next;
    logic [msss_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                         busy_reg, busy_next;
    msss_pkg::bcd_t               adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < msss_pkg::DIGITS; i++) begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                         : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start) begin
            bin_next  = value;
            bcd_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next  = {adj[msss_pkg::BCD_W-2:0], bin_reg[msss_pkg::VALUE_W-1]};
            bin_next  = {bin_reg[msss_pkg::VALUE_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd  = bcd_reg;
    assign stat = '{busy: busy_reg, done: busy_reg && (step_reg == LAST_STEP)};

endmodule

`default_nettype wire

>>> hdl/multiplexed_seven_segment_scan.sv
// ---------------------------------------------------------------------------
// multiplexed_seven_segment_scan: 8-digit multiplexed 7-segment scan driver
// Converts a value to decimal and emits one digit transfer per shown digit,
// most significant first, leading zeros suppressed.
// ---------------------------------------------------------------------------
//  channel | direction | ports                                   | transfer
//  --------+-----------+-----------------------------------------+----------------
//  s_      | in        | s_valid s_ready s_value                 | one value
//  m_      | out       | m_valid m_ready m_line_a/b/c m_segments | one digit
//          |           | m_last_digit                            |
//
//  Sequence: a value in range is accepted, converted in the shift/add-3 unit,
//  scanned past its leading zeros from the top digit down, and then sent out
//  one digit per transfer, most significant first.
//  A value of 10^NUM_DIGITS or more is dropped in its accept cycle.
//  Reset (aresetn low, synchronous) returns to idle with no pending transfer.
//  Output stalls hold the sequencer; s_ready is high only when idle, and the
//  last digit may still sit in the output register while a new value enters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_seven_segment_scan #(
    parameter int NUM_DIGITS = 8            // 1..8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic [msss_pkg::VALUE_W-1:0]  s_value,
    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      logic                          m_line_a,
    output      logic                          m_line_b,
    output      logic                          m_line_c,
    output      logic [msss_pkg::SEG_W-1:0]    m_segments,
    output      logic                          m_last_digit
);

    // largest shown value plus one; 10^8 still fits in 27 bits
    localparam logic [msss_pkg::VALUE_W-1:0] LIMIT =
        msss_pkg::VALUE_W'(msss_pkg::pow10(NUM_DIGITS));
    localparam logic [msss_pkg::IDX_W-1:0]   TOP_IDX =
        msss_pkg::IDX_W'(NUM_DIGITS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;   // converter running
    localparam logic [1:0] ST_SCAN = 2'd2;   // skip leading zeros
    localparam logic [1:0] ST_EMIT = 2'd3;   // one digit per output slot

    logic [1:0]                  state_reg, state_next;
    logic [msss_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        line_a_reg, line_b_reg, line_c_reg, last_reg;
    msss_pkg::seg_t              seg_reg;

    logic                        s_fire;
    logic                        in_range;
    logic                        start;
    logic                        load_out;
    msss_pkg::bcd_t              bcd;
    msss_pkg::dab_stat_t         dab_stat;
    msss_pkg::digit_t            cur_digit;

    msss_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .value   (s_value),
        .bcd     (bcd),
        .stat    (dab_stat)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign in_range  = (s_value < LIMIT);
    assign start     = s_fire && in_range;
    assign cur_digit = bcd[4*idx_reg +: 4];

    // output slot is free when empty or being drained this cycle
    assign load_out  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (dab_stat.done) begin
                    state_next = ST_SCAN;
                    idx_next   = TOP_IDX;
                end
            end
            ST_SCAN: begin
                // zero itself shows as a single units digit
                if (idx_reg == '0 || cur_digit != 4'd0) begin
                    state_next = ST_EMIT;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_EMIT: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        if (load_out) begin
            // select code is position minus one: b = bit 0, a = bit 1, c = bit 2
            line_a_reg <= idx_reg[1];
            line_b_reg <= idx_reg[0];
            line_c_reg <= idx_reg[2];
            seg_reg    <= msss_pkg::seg_encode(cur_digit);
            last_reg   <= (idx_reg == '0);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_line_a     = line_a_reg;
    assign m_line_b     = line_b_reg;
    assign m_line_c     = line_c_reg;
    assign m_segments   = seg_reg;
    assign m_last_digit = last_reg;

    // out-of-range values are dropped without leaving idle
    a_drop_large: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !in_range) |=> (state_reg == ST_IDLE))
        else $error("out-of-range value started a run");

    // converter must be running for the whole conversion phase
    a_conv_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |-> dab_stat.busy)
        else $error("conversion phase without busy converter");

    // converter only finishes while the sequencer waits for it
    a_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        dab_stat.done |-> (state_reg == ST_CONV))
        else $error("converter finished outside conversion phase");

    // the units digit closes the run and carries the last flag
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && idx_reg == '0) |=> (state_reg == ST_IDLE && m_valid && m_last_digit))
        else $error("run did not end on the units digit");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the 8-digit seven-segment scan driver
// Values go in over the s_ channel, and every digit transfer that comes out
// on the m_ channel is checked against an in-bench digit splitter and
// segment encoder. Pacing runs through four phases: free-running, sender
// gaps, receiver stalls, and both together.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    // Display geometry of the instance under test (default NUM_DIGITS)
    localparam int unsigned SHOWN_DIGITS = 8;

    // gfedcba patterns for 0..9, digit d lives at [7*d +: 7]
    localparam logic [69:0] GLYPH_ROM = {
        7'h6f, 7'h7f, 7'h07, 7'h7d, 7'h6d, 7'h66, 7'h4f, 7'h5b, 7'h06, 7'h3f
    };

    // The block drops an out-of-range value in its accept cycle, but an
    // in-range value still runs through conversion and output, so idle at the end.
    localparam int TAIL_CYCLES = 60;

    // One digit transfer as the m_ channel presents it
    typedef struct packed {
        logic                       sel_a;
        logic                       sel_b;
        logic                       sel_c;
        logic [msss_pkg::SEG_W-1:0] glyph;
        logic                       units;
    } digit_xfer_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [msss_pkg::VALUE_W-1:0] s_value = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_line_a;
    logic                         m_line_b;
    logic                         m_line_c;
    logic [msss_pkg::SEG_W-1:0]   m_segments;
    logic                         m_last_digit;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    multiplexed_seven_segment_scan dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_line_a    (m_line_a),
        .m_line_b    (m_line_b),
        .m_line_c    (m_line_c),
        .m_segments  (m_segments),
        .m_last_digit(m_last_digit)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    logic [msss_pkg::VALUE_W-1:0] values_to_send[$];    // values not yet presented
    digit_xfer_t                  expected_digits[$];   // digits still owed by the DUT

    int idle_pct  = 0;      // chance (percent) the sender idles on a cycle
    int stall_pct = 0;      // chance (percent) the receiver drops m_ready
    logic value_taken = 1'b0;   // s_ transfer happened at the last rising edge

    int err_count      = 0;
    int values_taken   = 0;
    int values_dropped = 0;
    int digits_checked = 0;

    // ------------------------------------------------------------------
    // Digit predictor: splits an accepted value into decimal digits and
    // queues one expected transfer per digit, most significant first.
    // Leading zeros are suppressed, zero still shows a single 0, and a
    // value of 10^SHOWN_DIGITS or more produces nothing at all.
    // ------------------------------------------------------------------
    task automatic predict_digits(input logic [msss_pkg::VALUE_W-1:0] value);
        int unsigned limit;
        int unsigned rest;
        int unsigned digs[8];
        int          count;
        logic [2:0]  code;
        digit_xfer_t xfer;
        limit = 1;
        for (int i = 0; i < SHOWN_DIGITS; i++) begin
            limit = limit * 10;
        end
        if (value >= limit) begin
            values_dropped++;
            return;
        end
        rest  = value;
        count = 1;
        for (int i = 0; i < 8; i++) begin
            digs[i] = rest % 10;
            rest    = rest / 10;
            if (digs[i] != 0) begin
                count = i + 1;
            end
        end
        for (int p = count; p >= 1; p--) begin
            code       = 3'(p - 1);
            xfer.sel_a = code[1];
            xfer.sel_b = code[0];
            xfer.sel_c = code[2];
            xfer.glyph = GLYPH_ROM[7*digs[p-1] +: 7];
            xfer.units = (p == 1);
            expected_digits.push_back(xfer);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: everything changes on the falling edge. A presented value
    // stays put until its transfer; the next one may follow back to back
    // with s_valid kept high, so s_valid gets a single update per edge.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : value_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !value_taken) begin
            // hold: value still waiting for s_ready
        end else if (values_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
            s_value <= values_to_send.pop_front();
            s_valid <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin : ready_driver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels on the rising edge. Predictions are
    // made for accepted values, digits are matched against the oldest one.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        digit_xfer_t want;
        if (aresetn) begin
            value_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                values_taken++;
                predict_digits(s_value);
            end
            if (m_valid && m_ready) begin
                if (expected_digits.size() == 0) begin
                    report_mismatch("unexpected digit, segments", int'(m_segments), 0);
                end else begin
                    want = expected_digits.pop_front();
                    digits_checked++;
                    if (m_line_a !== want.sel_a)
                        report_mismatch("line_a", int'(m_line_a), int'(want.sel_a));
                    if (m_line_b !== want.sel_b)
                        report_mismatch("line_b", int'(m_line_b), int'(want.sel_b));
                    if (m_line_c !== want.sel_c)
                        report_mismatch("line_c", int'(m_line_c), int'(want.sel_c));
                    if (m_segments !== want.glyph)
                        report_mismatch("segments", int'(m_segments), int'(want.glyph));
                    if (m_last_digit !== want.units)
                        report_mismatch("last_digit", int'(m_last_digit), int'(want.units));
                end
            end
        end else begin
            value_taken <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly displayable values with a random digit count and plenty of
    // inner zeros; about one in eight is above the display range.
    task automatic add_random_values(input int n_shown);
        int          made;
        int          n_digs;
        int unsigned v;
        int unsigned d;
        made = 0;
        while (made < n_shown) begin
            if ($urandom_range(99) < 12) begin
                if ($urandom_range(3) == 0)
                    v = 100000000;
                else
                    v = $urandom_range(134217727, 100000000);
            end else begin
                n_digs = $urandom_range(8, 1);
                v = $urandom_range(9, 1);
                for (int i = 1; i < n_digs; i++) begin
                    d = ($urandom_range(99) < 30) ? 0 : $urandom_range(9, 0);
                    v = v * 10 + d;
                end
                made++;
            end
            values_to_send.push_back(msss_pkg::VALUE_W'(v));
        end
    endtask

    // Sender pause: nothing new until every owed digit has arrived
    task automatic wait_drained();
        while (values_to_send.size() != 0 || s_valid || expected_digits.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic set_pacing(input int sender_idle, input int receiver_stall);
        @(negedge aclk);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: zero, all-ones, every digit-count boundary, both sides
        // of the display range, every glyph and inner zeros.
        set_pacing(0, 0);
        values_to_send.push_back(msss_pkg::VALUE_W'(0));
        values_to_send.push_back(msss_pkg::VALUE_W'(1));
        values_to_send.push_back(msss_pkg::VALUE_W'(5));
        values_to_send.push_back(msss_pkg::VALUE_W'(9));
        values_to_send.push_back(msss_pkg::VALUE_W'(10));
        values_to_send.push_back(msss_pkg::VALUE_W'(99));
        values_to_send.push_back(msss_pkg::VALUE_W'(100));
        values_to_send.push_back(msss_pkg::VALUE_W'(999));
        values_to_send.push_back(msss_pkg::VALUE_W'(1000));
        values_to_send.push_back(msss_pkg::VALUE_W'(9999));
        values_to_send.push_back(msss_pkg::VALUE_W'(10000));
        values_to_send.push_back(msss_pkg::VALUE_W'(99999));
        values_to_send.push_back(msss_pkg::VALUE_W'(100000));
        values_to_send.push_back(msss_pkg::VALUE_W'(999999));
        values_to_send.push_back(msss_pkg::VALUE_W'(1000000));
        values_to_send.push_back(msss_pkg::VALUE_W'(9999999));
        values_to_send.push_back(msss_pkg::VALUE_W'(10000000));
        values_to_send.push_back(msss_pkg::VALUE_W'(12345678));
        values_to_send.push_back(msss_pkg::VALUE_W'(87654321));
        values_to_send.push_back(msss_pkg::VALUE_W'(10203040));
        values_to_send.push_back(msss_pkg::VALUE_W'(90000009));
        values_to_send.push_back(msss_pkg::VALUE_W'(99999999));
        values_to_send.push_back(msss_pkg::VALUE_W'(100000000));   // just out of range
        values_to_send.push_back(msss_pkg::VALUE_W'(134217727));   // all input bits set
        values_to_send.push_back(msss_pkg::VALUE_W'(0));           // zero after a drop

        // Random traffic, one pacing phase at a time, draining in between
        add_random_values(41);
        wait_drained();

        set_pacing(56, 0);
        add_random_values(41);
        wait_drained();

        set_pacing(0, 56);
        add_random_values(41);
        wait_drained();

        set_pacing(16, 16);
        add_random_values(40);
        wait_drained();

        // Quiet tail: anything spurious from the DUT still gets flagged
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (expected_digits.size() != 0)
            report_mismatch("digits left outstanding", expected_digits.size(), 0);

        $display("Covered %0d values (%0d above display range), %0d digit transfers checked",
                 values_taken, values_dropped, digits_checked);
        $display("Pacing: free run, sender gaps, receiver stalls, and both combined");
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #6000000;
        $display("Timeout with %0d digits outstanding", expected_digits.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
